// ===== src/fsa_pkg.sv =====
// ----------------------------------------------------------------------------
// fsa_pkg: shared types and constants of the fraction sum accumulator
// Payload structs, controller command codes and the datapath status group.
// ----------------------------------------------------------------------------
package fsa_pkg;

    localparam int VALUE_W = 31;
    localparam int PROD_W  = 2 * VALUE_W;
    localparam int CNT_W   = $clog2(VALUE_W);

    typedef struct packed {
        logic [VALUE_W-1:0] frac_num;
        logic [VALUE_W-1:0] frac_den;
        logic               last;
    } fsa_in_t;

    typedef struct packed {
        logic [VALUE_W-1:0] sum_num;
        logic [VALUE_W-1:0] sum_den;
        logic               overflow;
    } fsa_out_t;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_EUC_DIV,
        CMD_EUC_STEP,
        CMD_DIV_Q1,
        CMD_SAVE_Q1,
        CMD_DIV_Q2,
        CMD_SAVE_Q2,
        CMD_MUL_LCM,
        CMD_SAVE_LCM,
        CMD_MUL_NA,
        CMD_SAVE_NA,
        CMD_MUL_NB,
        CMD_SAVE_SUM,
        CMD_ZERO_TOTAL,
        CMD_LOAD_EUC2,
        CMD_DIV_NUM,
        CMD_SAVE_NUM,
        CMD_DIV_DEN,
        CMD_SAVE_DEN,
        CMD_DROP,
        CMD_EMIT
    } fsa_cmd_t;

    typedef struct packed {
        logic b_zero;
        logic div_done;
        logic prod_ovf;
        logic sum_ovf;
        logic sum_zero;
        logic last;
        logic out_full;
    } fsa_status_t;

endpackage

// ===== src/fsa_div.sv =====
// ----------------------------------------------------------------------------
// fsa_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle; quotient and remainder
// hold until the next start.
// ----------------------------------------------------------------------------
module fsa_div
    import fsa_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [VALUE_W-1:0] dividend,
    input  logic [VALUE_W-1:0] divisor,
    output logic               done,
    output logic [VALUE_W-1:0] quot,
    output logic [VALUE_W-1:0] rem
);

    logic [VALUE_W-1:0] q_reg, q_next;
    logic [VALUE_W-1:0] r_reg, r_next;
    logic [VALUE_W-1:0] d_reg, d_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [VALUE_W:0]   partial;
    logic [VALUE_W:0]   trial;

    assign partial = {r_reg, q_reg[VALUE_W-1]};
    assign trial   = partial - {1'b0, d_reg};

    always_comb begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
            cnt_next  = CNT_W'(VALUE_W - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[VALUE_W]) begin
                r_next = trial[VALUE_W-1:0];
                q_next = {q_reg[VALUE_W-2:0], 1'b1};
            end else begin
                r_next = partial[VALUE_W-1:0];
                q_next = {q_reg[VALUE_W-2:0], 1'b0};
            end
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        q_reg   <= q_next;
        r_reg   <= r_next;
        d_reg   <= d_next;
        cnt_reg <= cnt_next;
    end

    assign done = done_reg;
    assign quot = q_reg;
    assign rem  = r_reg;

endmodule

// ===== src/fsa_dp.sv =====
// ----------------------------------------------------------------------------
// fsa_dp: datapath of the fraction sum accumulator
// Running total, gcd operands, one multiplier, the shared divider and the
// result register, all driven by controller commands.
// ----------------------------------------------------------------------------
module fsa_dp
    import fsa_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  fsa_cmd_t    cmd,
    output fsa_status_t status,
    input  fsa_in_t     s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output fsa_out_t    m_data
);

    logic [VALUE_W-1:0] tn_reg, tn_next;
    logic [VALUE_W-1:0] td_reg, td_next;
    logic               ovf_reg, ovf_next;
    logic               m_valid_reg, m_valid_next;

    logic [VALUE_W-1:0] fn_reg, fd_reg;
    logic               last_reg;
    logic [VALUE_W-1:0] a_reg, b_reg;
    logic [VALUE_W-1:0] q1_reg, q2_reg;
    logic [VALUE_W-1:0] lcm_reg, na_reg, sum_reg;
    logic [PROD_W-1:0]  prod_reg;
    fsa_out_t           out_reg;

    logic               div_start;
    logic [VALUE_W-1:0] div_dividend, div_divisor;
    logic               div_done;
    logic [VALUE_W-1:0] div_quot, div_rem;
    logic [VALUE_W-1:0] mul_a, mul_b;
    logic [VALUE_W:0]   sum_wide;
    logic               prod_ovf;

    fsa_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    always_comb begin
        div_start    = 1'b1;
        div_dividend = a_reg;
        div_divisor  = b_reg;
        case (cmd)
            CMD_EUC_DIV: begin
                div_dividend = a_reg;
                div_divisor  = b_reg;
            end
            CMD_DIV_Q1: begin
                div_dividend = td_reg;
                div_divisor  = a_reg;
            end
            CMD_DIV_Q2: begin
                div_dividend = fd_reg;
                div_divisor  = a_reg;
            end
            CMD_DIV_NUM: begin
                div_dividend = sum_reg;
                div_divisor  = a_reg;
            end
            CMD_DIV_DEN: begin
                div_dividend = lcm_reg;
                div_divisor  = a_reg;
            end
            default: div_start = 1'b0;
        endcase
    end

    always_comb begin
        mul_a = q1_reg;
        mul_b = fd_reg;
        case (cmd)
            CMD_MUL_NA: begin
                mul_a = q2_reg;
                mul_b = tn_reg;
            end
            CMD_MUL_NB: begin
                mul_a = q1_reg;
                mul_b = fn_reg;
            end
            default: begin
                mul_a = q1_reg;
                mul_b = fd_reg;
            end
        endcase
    end

    assign prod_ovf = |prod_reg[PROD_W-1:VALUE_W];
    assign sum_wide = {1'b0, na_reg} + {1'b0, prod_reg[VALUE_W-1:0]};

    always_comb begin
        tn_next      = tn_reg;
        td_next      = td_reg;
        ovf_next     = ovf_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (cmd)
            CMD_ZERO_TOTAL: begin
                tn_next = '0;
                td_next = VALUE_W'(1);
            end
            CMD_SAVE_NUM: tn_next = div_quot;
            CMD_SAVE_DEN: td_next = div_quot;
            CMD_DROP:     ovf_next = 1'b1;
            CMD_EMIT: begin
                tn_next      = '0;
                td_next      = VALUE_W'(1);
                ovf_next     = 1'b0;
                m_valid_next = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tn_reg      <= '0;
            td_reg      <= VALUE_W'(1);
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            tn_reg      <= tn_next;
            td_reg      <= td_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd)
            CMD_LOAD: begin
                fn_reg   <= s_data.frac_num;
                fd_reg   <= (s_data.frac_den == '0) ? VALUE_W'(1) : s_data.frac_den;
                last_reg <= s_data.last;
                a_reg    <= td_reg;
                b_reg    <= (s_data.frac_den == '0) ? VALUE_W'(1) : s_data.frac_den;
            end
            CMD_EUC_STEP: begin
                a_reg <= b_reg;
                b_reg <= div_rem;
            end
            CMD_SAVE_Q1:  q1_reg <= div_quot;
            CMD_SAVE_Q2:  q2_reg <= div_quot;
            CMD_MUL_LCM,
            CMD_MUL_NA,
            CMD_MUL_NB:   prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
            CMD_SAVE_LCM: lcm_reg <= prod_reg[VALUE_W-1:0];
            CMD_SAVE_NA:  na_reg <= prod_reg[VALUE_W-1:0];
            CMD_SAVE_SUM: sum_reg <= sum_wide[VALUE_W-1:0];
            CMD_LOAD_EUC2: begin
                a_reg <= sum_reg;
                b_reg <= lcm_reg;
            end
            CMD_EMIT: begin
                out_reg.sum_num  <= tn_reg;
                out_reg.sum_den  <= td_reg;
                out_reg.overflow <= ovf_reg;
            end
            default: ;
        endcase
    end

    assign status.b_zero   = (b_reg == '0);
    assign status.div_done = div_done;
    assign status.prod_ovf = prod_ovf;
    assign status.sum_ovf  = sum_wide[VALUE_W];
    assign status.sum_zero = (sum_reg == '0);
    assign status.last     = last_reg;
    assign status.out_full = m_valid_reg;

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // the total's denominator is never zero
    a_td_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        td_reg != '0)
        else $error("total denominator became zero");

    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> div_divisor != '0)
        else $error("divider started with zero divisor");

    a_save_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd == CMD_SAVE_LCM || cmd == CMD_SAVE_NA || cmd == CMD_SAVE_SUM) |-> !prod_ovf)
        else $error("overflowing product kept");

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd == CMD_EMIT |-> !m_valid_reg)
        else $error("result register overwritten");

    a_emit_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd == CMD_EMIT |=> m_valid_reg && tn_reg == '0 && td_reg == VALUE_W'(1) && !ovf_reg)
        else $error("total not restarted after emit");

endmodule

// ===== src/fsa_ctrl.sv =====
// ----------------------------------------------------------------------------
// fsa_ctrl: sequencer of the fraction sum accumulator
// Steps one fraction through gcd, lcm, scaling, sum and reduction by
// issuing datapath commands.
// ----------------------------------------------------------------------------
module fsa_ctrl
    import fsa_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  fsa_status_t status,
    output fsa_cmd_t    cmd
);

    typedef enum logic [20:0] {
        ST_IDLE   = 21'h000001,
        ST_EUC1   = 21'h000002,
        ST_EUC1_W = 21'h000004,
        ST_Q1     = 21'h000008,
        ST_Q1_W   = 21'h000010,
        ST_Q2     = 21'h000020,
        ST_Q2_W   = 21'h000040,
        ST_MLCM   = 21'h000080,
        ST_CLCM   = 21'h000100,
        ST_MNA    = 21'h000200,
        ST_CNA    = 21'h000400,
        ST_MNB    = 21'h000800,
        ST_CNB    = 21'h001000,
        ST_SUMCHK = 21'h002000,
        ST_EUC2   = 21'h004000,
        ST_EUC2_W = 21'h008000,
        ST_DNUM   = 21'h010000,
        ST_DNUM_W = 21'h020000,
        ST_DDEN   = 21'h040000,
        ST_DDEN_W = 21'h080000,
        ST_FIN    = 21'h100000
    } fsa_state_t;

    fsa_state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = CMD_NONE;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd        = CMD_LOAD;
                    state_next = ST_EUC1;
                end
            end
            ST_EUC1: begin
                if (status.b_zero) begin
                    state_next = ST_Q1;
                end else begin
                    cmd        = CMD_EUC_DIV;
                    state_next = ST_EUC1_W;
                end
            end
            ST_EUC1_W: begin
                if (status.div_done) begin
                    cmd        = CMD_EUC_STEP;
                    state_next = ST_EUC1;
                end
            end
            ST_Q1: begin
                cmd        = CMD_DIV_Q1;
                state_next = ST_Q1_W;
            end
            ST_Q1_W: begin
                if (status.div_done) begin
                    cmd        = CMD_SAVE_Q1;
                    state_next = ST_Q2;
                end
            end
            ST_Q2: begin
                cmd        = CMD_DIV_Q2;
                state_next = ST_Q2_W;
            end
            ST_Q2_W: begin
                if (status.div_done) begin
                    cmd        = CMD_SAVE_Q2;
                    state_next = ST_MLCM;
                end
            end
            ST_MLCM: begin
                cmd        = CMD_MUL_LCM;
                state_next = ST_CLCM;
            end
            ST_CLCM: begin
                if (status.prod_ovf) begin
                    cmd        = CMD_DROP;
                    state_next = ST_FIN;
                end else begin
                    cmd        = CMD_SAVE_LCM;
                    state_next = ST_MNA;
                end
            end
            ST_MNA: begin
                cmd        = CMD_MUL_NA;
                state_next = ST_CNA;
            end
            ST_CNA: begin
                if (status.prod_ovf) begin
                    cmd        = CMD_DROP;
                    state_next = ST_FIN;
                end else begin
                    cmd        = CMD_SAVE_NA;
                    state_next = ST_MNB;
                end
            end
            ST_MNB: begin
                cmd        = CMD_MUL_NB;
                state_next = ST_CNB;
            end
            ST_CNB: begin
                if (status.prod_ovf || status.sum_ovf) begin
                    cmd        = CMD_DROP;
                    state_next = ST_FIN;
                end else begin
                    cmd        = CMD_SAVE_SUM;
                    state_next = ST_SUMCHK;
                end
            end
            ST_SUMCHK: begin
                // a zero sum is kept as 0/1 without reduction
                if (status.sum_zero) begin
                    cmd        = CMD_ZERO_TOTAL;
                    state_next = ST_FIN;
                end else begin
                    cmd        = CMD_LOAD_EUC2;
                    state_next = ST_EUC2;
                end
            end
            ST_EUC2: begin
                if (status.b_zero) begin
                    state_next = ST_DNUM;
                end else begin
                    cmd        = CMD_EUC_DIV;
                    state_next = ST_EUC2_W;
                end
            end
            ST_EUC2_W: begin
                if (status.div_done) begin
                    cmd        = CMD_EUC_STEP;
                    state_next = ST_EUC2;
                end
            end
            ST_DNUM: begin
                cmd        = CMD_DIV_NUM;
                state_next = ST_DNUM_W;
            end
            ST_DNUM_W: begin
                if (status.div_done) begin
                    cmd        = CMD_SAVE_NUM;
                    state_next = ST_DDEN;
                end
            end
            ST_DDEN: begin
                cmd        = CMD_DIV_DEN;
                state_next = ST_DDEN_W;
            end
            ST_DDEN_W: begin
                if (status.div_done) begin
                    cmd        = CMD_SAVE_DEN;
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                // hold a finished total until the result register is free
                if (!status.last) begin
                    state_next = ST_IDLE;
                end else if (!status.out_full) begin
                    cmd        = CMD_EMIT;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

endmodule

// ===== src/fraction_sum_accumulator_unit.sv =====
// ----------------------------------------------------------------------------
// fraction_sum_accumulator_unit: running sum of positive fractions
// Adds fractions over the lcm of the denominators and keeps the total reduced.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data carry one fraction per request (numerator,
//   denominator, last mark). A denominator of zero counts as one.
//   m_valid/m_ready/m_data carry the reduced total after each request with
//   the last mark set, with a sticky overflow flag; the total then restarts
//   at 0/1. A fraction whose lcm, scaled numerators or sum would leave the
//   31-bit range is dropped and only sets the overflow flag.
// Timing:
//   One fraction at a time. Each division runs in the shared iterative divider;
//   an item needs (k1 + k2 + 4) divisions, where k1 and k2 are the Euclid
//   step counts of the two gcd searches (at most 45 each for 31-bit values).
// Reset and stall:
//   aresetn (synchronous, active low) clears the total to 0/1 and drops any
//   pending result. A result waiting in the output register does not block
//   new requests; only the next last-marked item holds until it is taken.
// ----------------------------------------------------------------------------
module fraction_sum_accumulator_unit
    import fsa_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  fsa_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output fsa_out_t m_data
);

    fsa_cmd_t    cmd;
    fsa_status_t status;

    fsa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    fsa_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .status  (status),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// ===== dv/fraction_sum_accumulator_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fraction_sum_accumulator_unit_test: self-checking bench for the fraction summer
// Offers groups of fractions with random gaps on both channels. A reduced-fraction
// model in the bench, or the table value of a checked row, predicts each emitted
// total, and every result is compared with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module fraction_sum_accumulator_unit_test;
    import fsa_pkg::*;

    localparam logic [63:0]        VMAX         = (64'd1 << VALUE_W) - 64'd1;
    localparam logic [VALUE_W-1:0] FMAX         = '1;
    localparam int                 RANDOM_ITEMS = 300;
    localparam int                 HOLD_CYCLES  = 12000;
    localparam int                 DRAIN_CYCLES = 4000;
    localparam int                 CYCLE_LIMIT  = 6000000;

    typedef enum int {SPAN_TINY, SPAN_MID, SPAN_FULL} span_t;

    typedef struct {
        fsa_in_t  req;
        bit       typed;
        fsa_out_t want;
    } stim_row_t;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    fsa_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    fsa_out_t m_data;

    stim_row_t   stim_table[$];
    fsa_out_t    pending_totals[$];
    logic [63:0] run_num = 64'd0;
    logic [63:0] run_den = 64'd1;
    bit          run_ovf = 1'b0;
    int          mismatch_count = 0;
    int          cycle_count = 0;
    bit          hold_output = 1'b0;
    bit          send_calm = 1'b0;
    bit          recv_calm = 1'b0;

    fraction_sum_accumulator_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic logic [63:0] euclid_gcd(logic [63:0] a, logic [63:0] b);
        logic [63:0] r;
        while (b != 0) begin
            r = a % b;
            a = b;
            b = r;
        end
        return a;
    endfunction

    function automatic bit product_fits(input logic [63:0] a, input logic [63:0] b,
                                        output logic [63:0] p);
        p = 64'd0;
        if (a == 0)
            return 1'b1;
        if (b > VMAX / a)
            return 1'b0;
        p = a * b;
        return 1'b1;
    endfunction

    // Fold one fraction into the running total; return 1 when it closes a sum.
    function automatic bit advance_total(input fsa_in_t req, output fsa_out_t total);
        logic [63:0] fn, fd, g, lcm, na, nb, sum;
        bit          fits;
        fn = 64'(req.frac_num);
        fd = (req.frac_den == 0) ? 64'd1 : 64'(req.frac_den);
        g  = euclid_gcd(run_den, fd);
        na = 64'd0;
        nb = 64'd0;
        lcm = 64'd1;
        fits = (fn <= VMAX) && (fd <= VMAX)
            && product_fits(run_den / g, fd, lcm)
            && product_fits(lcm / run_den, run_num, na)
            && product_fits(lcm / fd, fn, nb)
            && (nb <= VMAX - na);
        if (!fits) begin
            // drop the fraction, keep the total
            run_ovf = 1'b1;
        end else begin
            sum = na + nb;
            if (sum == 0) begin
                run_num = 64'd0;
                run_den = 64'd1;
            end else begin
                g = euclid_gcd(sum, lcm);
                run_num = sum / g;
                run_den = lcm / g;
            end
        end
        total.sum_num  = run_num[VALUE_W-1:0];
        total.sum_den  = run_den[VALUE_W-1:0];
        total.overflow = run_ovf;
        if (!req.last)
            return 1'b0;
        run_num = 64'd0;
        run_den = 64'd1;
        run_ovf = 1'b0;
        return 1'b1;
    endfunction

    function automatic int draw_gap(inout bit calm);
        if ($urandom_range(0, 19) == 0)
            calm = !calm;
        return calm ? 0 : int'($urandom_range(0, 13));
    endfunction

    function automatic logic [VALUE_W-1:0] draw_value(span_t span);
        case (span)
            SPAN_TINY: begin
                return VALUE_W'($urandom_range(1, 64));
            end
            SPAN_MID: begin
                return VALUE_W'($urandom_range(1, 4095));
            end
            default: begin
                return VALUE_W'($urandom()) & FMAX;
            end
        endcase
    endfunction

    function automatic void add_row(logic [VALUE_W-1:0] num, logic [VALUE_W-1:0] den,
                                    logic last);
        stim_row_t row;
        row.req.frac_num = num;
        row.req.frac_den = den;
        row.req.last     = last;
        row.typed        = 1'b0;
        row.want         = '0;
        stim_table.push_back(row);
    endfunction

    function automatic void add_checked(logic [VALUE_W-1:0] num, logic [VALUE_W-1:0] den,
                                        logic [VALUE_W-1:0] wnum, logic [VALUE_W-1:0] wden,
                                        logic wovf);
        stim_row_t row;
        row.req.frac_num  = num;
        row.req.frac_den  = den;
        row.req.last      = 1'b1;
        row.typed         = 1'b1;
        row.want.sum_num  = wnum;
        row.want.sum_den  = wden;
        row.want.overflow = wovf;
        stim_table.push_back(row);
    endfunction

    task automatic offer_fraction(input fsa_in_t req);
        int gap;
        gap = draw_gap(send_calm);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (s_ready !== 1'b1);
    endtask

    initial begin : stimulus
        fsa_in_t  req;
        fsa_out_t total;
        int       sent;
        int       group_len;
        int       pick;
        span_t    span;

        add_checked(31'd5, 31'd7, 31'd5, 31'd7, 1'b0);
        add_checked(31'd0, 31'd0, 31'd0, 31'd1, 1'b0);
        add_checked(FMAX, FMAX, 31'd1, 31'd1, 1'b0);
        add_checked(FMAX, 31'd1, FMAX, 31'd1, 1'b0);
        add_checked(31'd1, FMAX, 31'd1, FMAX, 1'b0);
        add_checked(31'd0, FMAX, 31'd0, 31'd1, 1'b0);
        add_row(31'd1, 31'd2, 1'b0);
        add_row(31'd1, 31'd3, 1'b0);
        add_row(31'd1, 31'd6, 1'b1);
        // lcm out of range
        add_row(31'd1, FMAX, 1'b0);
        add_checked(31'd1, FMAX - 31'd1, 31'd1, FMAX, 1'b1);
        // flag must be clear again after the emit
        add_checked(31'd1, 31'd4, 31'd1, 31'd4, 1'b0);
        // numerator sum out of range
        add_row(FMAX, 31'd1, 1'b0);
        add_checked(31'd1, 31'd1, FMAX, 31'd1, 1'b1);
        // scaled numerator out of range
        add_row(FMAX, 31'd2, 1'b0);
        add_checked(31'd1, 31'd3, FMAX, 31'd2, 1'b1);
        add_checked(31'd6, 31'd4, 31'd3, 31'd2, 1'b0);
        add_row(31'd0, 31'd5, 1'b0);
        add_row(31'd3, 31'd9, 1'b1);
        add_row(31'h5555_5555, 31'h2AAA_AAAA, 1'b1);
        add_row(31'h2AAA_AAAA, 31'h5555_5555, 1'b1);
        add_row(31'd1, FMAX, 1'b0);
        add_row(31'd1, FMAX - 31'd1, 1'b0);
        add_row(31'd1, FMAX, 1'b1);

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (stim_table[i]) begin
            offer_fraction(stim_table[i].req);
            if (advance_total(stim_table[i].req, total))
                pending_totals.push_back(stim_table[i].typed ? stim_table[i].want : total);
        end

        // stall the result side once so the block backs up into its input
        hold_output = 1'b1;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            group_len = $urandom_range(1, 6);
            pick      = $urandom_range(0, 9);
            span      = (pick < 5) ? SPAN_TINY : (pick < 8) ? SPAN_MID : SPAN_FULL;
            for (int i = 0; i < group_len; i++) begin
                req.frac_num = ($urandom_range(0, 11) == 0) ? '0 : draw_value(span);
                req.frac_den = ($urandom_range(0, 11) == 0) ? '0 : draw_value(span);
                req.last     = (i == group_len - 1);
                offer_fraction(req);
                if (advance_total(req, total))
                    pending_totals.push_back(total);
                sent++;
            end
        end
        s_valid <= 1'b0;

        while (pending_totals.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin : result_check
        fsa_out_t want;
        int       gap;
        wait (aresetn === 1'b1);
        forever begin
            if (hold_output) begin
                hold_output = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                gap = draw_gap(recv_calm);
                if (gap > 0) begin
                    m_ready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            if (pending_totals.size() == 0) begin
                $error("unexpected result %0d/%0d overflow %0d",
                       m_data.sum_num, m_data.sum_den, m_data.overflow);
                mismatch_count++;
            end else begin
                want = pending_totals.pop_front();
                if (m_data.sum_num !== want.sum_num) begin
                    $error("sum_num: expected %0d, got %0d", want.sum_num, m_data.sum_num);
                    mismatch_count++;
                end
                if (m_data.sum_den !== want.sum_den) begin
                    $error("sum_den: expected %0d, got %0d", want.sum_den, m_data.sum_den);
                    mismatch_count++;
                end
                if (m_data.overflow !== want.overflow) begin
                    $error("overflow: expected %0d, got %0d", want.overflow, m_data.overflow);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
